// ===== rtl/tlmsh_pkg.sv =====
// Package for the two-lane multiply-swap hash: multiplier constants, length width,
// sequencer and job types, byte swap and tail packing helpers.
// No dependencies.
`timescale 1ns / 1ps

package tlmsh_pkg;

    localparam int          LENGTH_BITS = 32;
    localparam int          INDEX_BITS  = 29;
    localparam logic [31:0] LEN_MASK    = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF :
                                          32'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [63:0] MUL_A       = 64'h1591_aefa_5e7e_5a17;
    localparam logic [63:0] MUL_B       = 64'h2bb6_8635_66c4_e761;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        JOB_BULK_A = 2'd0,
        JOB_BULK_B = 2'd1,
        JOB_MIX_A  = 2'd2,
        JOB_MIX_B  = 2'd3
    } t_job;

    function automatic logic [63:0] bswap64(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = v[8*(7-i) +: 8];
        end
        return r;
    endfunction

    // Pack 4-, 2- and 1-byte groups of the tail word, first group highest.
    function automatic logic [63:0] pack_tail(input logic [63:0] w, input logic [2:0] n);
        logic [63:0] p;
        logic [5:0]  pos;
        p   = '0;
        pos = '0;
        if (n[2]) begin
            p   = {32'b0, w[31:0]};
            pos = 6'd32;
        end
        if (n[1]) begin
            p   = {p[47:0], 16'(w >> pos)};
            pos = pos + 6'd16;
        end
        if (n[0]) begin
            p = {p[55:0], 8'(w >> pos)};
        end
        return p;
    endfunction

endpackage

// ===== rtl/two_lane_multiply_swap_hash64.sv =====
// A word that needs no multiply is absorbed as it is accepted; a bulk word holds the input
// while the shared 32x32 multiplier forms its partial products (one partial product per cycle).
// A last word then runs 2 or 3 mixing rounds in the same multiplier, after which the hash is
// loaded into the output register from the done state.
// Reset (synchronous, active low) clears seed, lanes, index, length and all control state.
// Top level: two-lane multiply-swap hash. Depends on tlmsh_pkg.
`timescale 1ns / 1ps

module two_lane_multiply_swap_hash64 import tlmsh_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input words
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // [63:0] data_word, [95:64] total_length
    input  logic         i_s_tuser,   // [0] first_word
    input  logic         i_s_tlast,   // last_word
    // result words
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,   // [63:0] hash_value
    // seed register write
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [63:0]  i_cfg_data
);

    // Control and lane state
    t_state                r_state, n_state;
    t_job                  r_job, n_job;
    logic [1:0]            r_step, n_step;     // partial product number
    logic [1:0]            r_rounds, n_rounds; // mixing rounds still to run
    logic                  r_last, n_last;     // mix after the bulk multiply
    logic [63:0]           r_seed;
    logic [63:0]           r_lane_a, n_lane_a;
    logic [63:0]           r_lane_b, n_lane_b;
    logic [INDEX_BITS-1:0] r_index, n_index;
    logic [31:0]           r_length, n_length;
    logic                  r_out_valid, n_out_valid;

    // Multiplier datapath
    logic [63:0]           r_x, n_x;
    logic [63:0]           r_y, n_y;
    logic [127:0]          r_acc, n_acc;
    logic [63:0]           r_out_data, n_out_data;

    logic [31:0]           mul_a, mul_b;
    logic [63:0]           pp;
    logic [127:0]          pp_shifted;
    logic [127:0]          acc_sum;
    logic                  out_load;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Shared unit: one 32x32 partial product per cycle, accumulated at its weight.
    always_comb begin
        unique case (r_step)
            2'd0: begin
                mul_a = r_x[31:0];
                mul_b = r_y[31:0];
            end
            2'd1: begin
                mul_a = r_x[31:0];
                mul_b = r_y[63:32];
            end
            2'd2: begin
                mul_a = r_x[63:32];
                mul_b = r_y[31:0];
            end
            default: begin
                mul_a = r_x[63:32];
                mul_b = r_y[63:32];
            end
        endcase
    end

    assign pp = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        unique case (r_step)
            2'd0:    pp_shifted = {64'b0, pp};
            2'd1,
            2'd2:    pp_shifted = {32'b0, pp, 32'b0};
            default: pp_shifted = {pp, 64'b0};
        endcase
    end

    assign acc_sum = r_acc + pp_shifted;

    // Sequencer
    always_comb begin
        logic [63:0]           w;
        logic                  first;
        logic [31:0]           len;
        logic [63:0]           la, lb;
        logic [INDEX_BITS-1:0] idx, full, pairs;
        logic                  bulk;
        logic                  go_mix;

        n_state    = r_state;
        n_job      = r_job;
        n_step     = r_step;
        n_rounds   = r_rounds;
        n_last     = r_last;
        n_lane_a   = r_lane_a;
        n_lane_b   = r_lane_b;
        n_index    = r_index;
        n_length   = r_length;
        n_x        = r_x;
        n_y        = r_y;
        n_acc      = r_acc;
        n_out_data = r_out_data;
        out_load   = 1'b0;

        w      = i_s_tdata[63:0];
        first  = i_s_tuser;
        len    = first ? (i_s_tdata[95:64] & LEN_MASK) : r_length;
        la     = first ? 64'(len) : r_lane_a;
        lb     = first ? r_seed : r_lane_b;
        idx    = first ? '0 : r_index;
        full   = len[31:3];
        pairs  = {full[INDEX_BITS-1:1], 1'b0};
        bulk   = 1'b0;
        go_mix = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_length = len;
                    n_lane_a = la;
                    n_lane_b = lb;
                    n_last   = i_s_tlast;
                    n_rounds = (len[3:0] != 4'd0) ? 2'd3 : 2'd2;
                    n_index  = (idx != INDEX_MAX) ? idx + 1'b1 : idx;
                    priority if (idx < pairs) begin
                        bulk  = 1'b1;
                        n_acc = '0;
                        n_step = 2'd0;
                        n_state = S_MUL;
                        if (!idx[0]) begin
                            n_x   = la ^ w;
                            n_y   = MUL_A;
                            n_job = JOB_BULK_A;
                        end else begin
                            n_x   = lb ^ w;
                            n_y   = MUL_B;
                            n_job = JOB_BULK_B;
                        end
                    end else if (idx < full) begin
                        n_lane_a = la ^ w;
                    end else if (idx == full && len[2:0] != 3'd0) begin
                        n_lane_b = lb ^ pack_tail(w, len[2:0]);
                    end
                    // Last word with nothing to multiply: go straight to mixing.
                    go_mix = i_s_tlast && !bulk;
                end
            end
            S_MUL: begin
                n_acc  = acc_sum;
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    unique case (r_job)
                        JOB_BULK_A: begin
                            n_lane_a = bswap64(acc_sum[63:0]);
                            go_mix   = r_last;
                            n_state  = S_IDLE;
                        end
                        JOB_BULK_B: begin
                            n_lane_b = bswap64(acc_sum[63:0]);
                            go_mix   = r_last;
                            n_state  = S_IDLE;
                        end
                        JOB_MIX_A: begin
                            // Park low(P) in lane A; seed the B product with high(P).
                            n_lane_a = acc_sum[63:0];
                            n_x      = r_lane_b;
                            n_y      = MUL_B;
                            n_acc    = {64'b0, acc_sum[127:64]};
                            n_job    = JOB_MIX_B;
                        end
                        default: begin
                            n_lane_b = acc_sum[63:0];
                            n_lane_a = acc_sum[63:0] ^ r_lane_a;
                            n_rounds = r_rounds - 2'd1;
                            if (r_rounds == 2'd1) begin
                                n_state = S_DONE;
                            end else begin
                                go_mix = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_DONE: begin
                // Hold the hash until the output register is free.
                if (!r_out_valid || i_m_tready) begin
                    n_out_data = r_lane_a;
                    out_load   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Start a mixing round: P = A * MUL_A into the accumulator.
        if (go_mix) begin
            n_x     = n_lane_a;
            n_y     = MUL_A;
            n_acc   = '0;
            n_job   = JOB_MIX_A;
            n_step  = 2'd0;
            n_state = S_MUL;
        end

        n_out_valid = (r_out_valid && !i_m_tready) || out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= JOB_BULK_A;
            r_step      <= '0;
            r_rounds    <= '0;
            r_last      <= 1'b0;
            r_seed      <= '0;
            r_lane_a    <= '0;
            r_lane_b    <= '0;
            r_index     <= '0;
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_step      <= n_step;
            r_rounds    <= n_rounds;
            r_last      <= n_last;
            r_lane_a    <= n_lane_a;
            r_lane_b    <= n_lane_b;
            r_index     <= n_index;
            r_length    <= n_length;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    // Partial product count is parked at zero outside the multiply state.
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MUL) |-> (r_step == 2'd0))
        else $error("multiplier step counter left running");

    // A mixing job always has at least one round outstanding.
    a_rounds_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && (r_job == JOB_MIX_A || r_job == JOB_MIX_B)) |-> (r_rounds != 2'd0))
        else $error("mixing round with no rounds left");

    // An accepted last word always starts the multiplier.
    a_last_mixes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> (r_state == S_MUL))
        else $error("last word did not start mixing");

    // Leaving the done state means the hash went to the output register.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_DONE || r_out_valid))
        else $error("hash dropped on the way out");

endmodule

// ===== bench/tb_two_lane_multiply_swap_hash64.sv =====
// Self-checking bench for two_lane_multiply_swap_hash64: directed keys, then random keys
// under several seeds, with random idling on both streams and one long output hold-off.
// Depends on tlmsh_pkg (LEN_MASK, MUL_A, MUL_B) and the RTL top level.
`timescale 1ns / 1ps

module tb_two_lane_multiply_swap_hash64 import tlmsh_pkg::*; ();

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;      // covers a bulk word plus three mixing rounds
    localparam int HOLD_CYCLES   = 1500;    // long output hold-off

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [95:0]  i_s_tdata;    // [63:0] data_word, [95:64] total_length
    logic         i_s_tuser;    // [0] first_word
    logic         i_s_tlast;    // last_word
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [63:0]  o_m_tdata;    // [63:0] hash_value
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [63:0]  i_cfg_data;

    // Shadow copy of the hash state, advanced on every accepted word.
    logic [63:0]  sh_seed;
    logic [63:0]  sh_lane_a;
    logic [63:0]  sh_lane_b;
    logic [28:0]  sh_index;
    logic [31:0]  sh_length;

    logic [63:0]  pending_hashes[$];
    int           mismatches;
    bit           no_idle;
    int           hold_ask;
    int           hold_seen;
    int           hold_left;
    int           stall_left;

    two_lane_multiply_swap_hash64 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // Hash prediction
    // ---------------------------------------------------------------------------------

    function automatic logic [63:0] byte_reverse(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r = {r[55:0], v[7:0]};
            v = v >> 8;
        end
        return r;
    endfunction

    // One 128-bit product round: high half folds into lane B, low half into lane A.
    function automatic void mix_lanes();
        logic [127:0] prod;
        prod      = {64'd0, sh_lane_a} * {64'd0, MUL_A};
        sh_lane_b = sh_lane_b * MUL_B + prod[127:64];
        sh_lane_a = sh_lane_b ^ prod[63:0];
    endfunction

    // Absorb one word into the shadow state; return 1 and the hash on a last word.
    function automatic bit hash_absorb(input logic [63:0] w, input logic [31:0] len,
                                       input bit first, input bit last,
                                       output logic [63:0] hash);
        logic [31:0] full_words;
        logic [31:0] paired;
        logic [31:0] idx;
        logic [63:0] prod;
        logic [63:0] packed_tail;
        logic [63:0] rest;
        hash = '0;
        if (first) begin
            sh_length = len & LEN_MASK;
            sh_lane_a = {32'd0, sh_length};
            sh_lane_b = sh_seed;
            sh_index  = '0;
        end
        full_words = {3'd0, sh_length[31:3]};
        paired     = full_words & ~32'd1;
        idx        = {3'd0, sh_index};
        if (idx < paired) begin
            // Even words feed lane A, odd words lane B.
            if (!idx[0]) begin
                prod      = (sh_lane_a ^ w) * MUL_A;
                sh_lane_a = byte_reverse(prod);
            end else begin
                prod      = (sh_lane_b ^ w) * MUL_B;
                sh_lane_b = byte_reverse(prod);
            end
        end else if (idx < full_words) begin
            sh_lane_a = sh_lane_a ^ w;
        end else if (idx == full_words && sh_length[2:0] != 3'd0) begin
            // Tail bytes: 4-byte group first, then 2, then 1, each shifted in below.
            packed_tail = '0;
            rest        = w;
            if (sh_length[2]) begin
                packed_tail = {32'd0, rest[31:0]};
                rest        = rest >> 32;
            end
            if (sh_length[1]) begin
                packed_tail = {packed_tail[47:0], rest[15:0]};
                rest        = rest >> 16;
            end
            if (sh_length[0]) begin
                packed_tail = {packed_tail[55:0], rest[7:0]};
            end
            sh_lane_b = sh_lane_b ^ packed_tail;
        end
        if (sh_index != '1) begin
            sh_index = sh_index + 29'd1;
        end
        if (!last) begin
            return 1'b0;
        end
        if (sh_length[3:0] != 4'd0) begin
            mix_lanes();
        end
        mix_lanes();
        mix_lanes();
        hash = sh_lane_a;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------

    // Mostly no gap, often a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 64'd0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic int key_words(input logic [31:0] len);
        return (len == 0) ? 1 : int'((len + 32'd7) >> 3);
    endfunction

    // Offer one word, hold it until accepted, then record its expected hash.
    task automatic send_word(input logic [63:0] w, input logic [31:0] len,
                             input bit first, input bit last);
        int          gap;
        logic [63:0] hash;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {len, w};
        i_s_tuser  <= first;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (hash_absorb(w, len, first, last, hash)) begin
            pending_hashes.push_back(hash);
        end
    endtask

    // Send n_words words of a key of length len; the length rides only on the first.
    task automatic send_key(input logic [31:0] len, input int n_words);
        for (int i = 0; i < n_words; i++) begin
            send_word(rand64(), (i == 0) ? len : $urandom, i == 0, i == n_words - 1);
        end
    endtask

    // Drop valid, let every pending hash arrive, then let any trailing work finish.
    task automatic drain_hashes();
        i_s_tvalid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sh_seed = v;
    endtask

    // ---------------------------------------------------------------------------------
    // Result checking and output-side idling
    // ---------------------------------------------------------------------------------

    function automatic void report_hash(input logic [63:0] got);
        logic [63:0] want;
        if (pending_hashes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("hash word with none pending: got %h", got);
            end
            return;
        end
        want = pending_hashes.pop_front();
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("hash_value mismatch: expected %h, got %h", want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                report_hash(o_m_tdata);
            end
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            // Hold-off first, then random stalls, else accept.
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 20) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // Words with no first word start from the all-zero reset state.
    task automatic test_headless_words();
        send_word(rand64(), $urandom, 1'b0, 1'b0);
        send_word(rand64(), $urandom, 1'b0, 1'b1);
    endtask

    // Zero length: one word with both flags, its data ignored.
    task automatic test_empty_key();
        send_word('1, 32'd0, 1'b1, 1'b1);
    endtask

    // Every tail size alone in one word.
    task automatic test_tail_lengths();
        for (int n = 1; n <= 7; n++) begin
            send_key(n, 1);
        end
    endtask

    // Leftover word, exact pair, leftover plus tail, pair plus leftover.
    task automatic test_full_words();
        send_word(64'd0, 32'd8, 1'b1, 1'b1);
        send_word('1, 32'd16, 1'b1, 1'b0);
        send_word(64'd0, $urandom, 1'b0, 1'b1);
        send_key(15, 2);
        send_key(24, 3);
    endtask

    // Words past the end of the key change nothing but the index.
    task automatic test_overrun_words();
        send_key(3, 3);
    endtask

    // Largest length, cut short after two bulk words.
    task automatic test_early_last();
        send_word(64'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word('1, 32'd0, 1'b0, 1'b1);
    endtask

    // A word after a last word, without a first word, carries on the old state.
    task automatic test_carry_on();
        send_word(rand64(), $urandom, 1'b0, 1'b1);
    endtask

    // Mostly well-formed keys with random content, plus broken sequences and noise.
    task automatic test_random_keys(input int n_items);
        int          sent;
        int          r;
        int          n;
        logic [31:0] len;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                len = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 48)
                                                   : $urandom_range(49, 160);
                n = key_words(len);
            end else if (r < 88) begin
                // early last word, often with a huge length
                len = $urandom_range(0, 1) ? $urandom : $urandom_range(9, 200);
                n   = $urandom_range(1, 6);
            end else if (r < 94) begin
                // extra words beyond the key
                len = $urandom_range(0, 40);
                n   = key_words(len) + $urandom_range(1, 4);
            end else begin
                // headless noise continuing the current state
                n = 1;
                send_word(rand64(), $urandom, 1'b0, $urandom_range(0, 3) == 0);
            end
            if (r < 94) begin
                send_key(len, n);
            end
            sent += n;
        end
    endtask

    // Hold the output off long enough that the block stalls its input.
    task automatic test_output_backpressure();
        hold_ask++;
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_key($urandom_range(0, 7), 1);
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------------------

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        sh_seed     = '0;
        sh_lane_a   = '0;
        sh_lane_b   = '0;
        sh_index    = '0;
        sh_length   = '0;
        mismatches  = 0;
        no_idle     = 1'b0;
        hold_ask    = 0;
        hold_seen   = 0;
        hold_left   = 0;
        stall_left  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, seed at its reset value
        test_headless_words();
        test_empty_key();
        test_tail_lengths();
        test_full_words();
        test_overrun_words();
        test_early_last();
        test_carry_on();
        drain_hashes();

        write_seed('1);
        test_random_keys(400);
        drain_hashes();

        // a stretch with no idling on either side
        write_seed({$urandom, $urandom});
        no_idle = 1'b1;
        test_random_keys(300);
        no_idle = 1'b0;
        drain_hashes();

        test_output_backpressure();
        drain_hashes();

        write_seed(64'd0);
        test_random_keys(400);
        drain_hashes();

        write_seed({$urandom, $urandom});
        test_random_keys(400);
        drain_hashes();

        write_seed(64'h8000_0000_0000_0001);
        test_random_keys(350);
        drain_hashes();

        if (mismatches == 0 && pending_hashes.size() == 0) begin
            $display("tb_two_lane_multiply_swap_hash64: PASS");
        end else begin
            $display("tb_two_lane_multiply_swap_hash64: FAIL");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_two_lane_multiply_swap_hash64: FAIL");
        $finish;
    end

endmodule
